>>> hdl/lwwd_pkg.sv
// ----------------------------------------------------------------------------
// lwwd_pkg
// Shared constants and controller/datapath interface types for the
// least-work window dispatcher.
// ----------------------------------------------------------------------------
package lwwd_pkg;

    localparam int WINDOW_COUNT = 4;
    localparam int QUEUE_SLOTS  = 64;
    localparam int TIME_BITS    = 8;

    localparam int WIN_W   = $clog2(WINDOW_COUNT);
    localparam int PTR_W   = $clog2(QUEUE_SLOTS);
    localparam int ADDR_W  = $clog2(WINDOW_COUNT * QUEUE_SLOTS);
    localparam int DEPTH   = WINDOW_COUNT * QUEUE_SLOTS;

    localparam int CFG_COUNT = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    localparam int WINDOW_W = 2;
    localparam int NUMBER_W = 16;
    localparam int TOTAL_W  = 14;
    localparam int BUS_W    = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (WINDOW_W + NUMBER_W + TOTAL_W + 2);

    // input kind codes
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_ARRIVE = 1'b1;

    // result type codes
    localparam logic RES_TICKET = 1'b0;
    localparam logic RES_CALL   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WITHDRAW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER    = 3'd3;

    localparam logic [CFG_W-1:0] SVC_OPEN_RST     = 8'd20;
    localparam logic [CFG_W-1:0] SVC_WITHDRAW_RST = 8'd15;
    localparam logic [CFG_W-1:0] SVC_DEPOSIT_RST  = 8'd10;
    localparam logic [CFG_W-1:0] SVC_OTHER_RST    = 8'd25;

    typedef struct packed {
        logic             capture;    // latch the accepted item
        logic             arrive;     // dispatch the latched arrival
        logic             rd_issue;   // read head job of window idx
        logic             rd_capture; // store read data for window idx
        logic             update;     // age/pop the head of window idx
        logic [WIN_W-1:0] idx;
    } lwwd_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic upd_emit;  // window idx completes on this tick
    } lwwd_status_t;

endpackage

>>> hdl/least_work_window_dispatcher_core.sv
// Arrival: the item is latched on accept, and the ticket enters the output register from
// S_ARR once that register is free. Tick: each FIFO head is read from the job memory
// (S_READ, S_CAP per window), then each window is updated in S_UPD, which waits while
// a call cannot enter a full output register. No new item is taken until S_IDLE.
// Reset (rst_n low, async): FIFOs empty, totals 0, counters 1, service times
// to defaults; job memory contents are not cleared.
// ----------------------------------------------------------------------------
// least_work_window_dispatcher_core
// Least-work-left dispatch of arrivals over FIFO service windows, with
// per-tick service aging and window calls.
// ----------------------------------------------------------------------------
module least_work_window_dispatcher_core
    import lwwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] business, rest zero
    input  logic [0:0]             s_axis_tuser,  // [0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] window, [17:2] number, [31:18] wait_ticks, [32] accepted,
    // [33] served_now, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser,  // [0] result_type
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    lwwd_cmd_t          cmd;
    lwwd_status_t       status;
    logic               out_type, out_accepted, out_served_now;
    logic [WINDOW_W-1:0] out_window;
    logic [NUMBER_W-1:0] out_number;
    logic [TOTAL_W-1:0]  out_wait;

    assign cfg_ready = 1'b1;

    lwwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lwwd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_business    (s_axis_tdata[BUS_W-1:0]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_type       (out_type),
        .out_window     (out_window),
        .out_number     (out_number),
        .out_wait       (out_wait),
        .out_accepted   (out_accepted),
        .out_served_now (out_served_now),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tuser[0] = out_type;
    assign m_axis_tdata    = {{OUT_PAD_W{1'b0}}, out_served_now, out_accepted,
                              out_wait, out_number, out_window};

endmodule

>>> hdl/lwwd_ctrl.sv
// ----------------------------------------------------------------------------
// lwwd_ctrl
// Sequencer: accepts one item, runs the arrival step or the head read and
// update sweep of a tick, stalling whenever a result cannot be placed.
// ----------------------------------------------------------------------------
module lwwd_ctrl
    import lwwd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_kind,
    output logic         in_ready,
    input  lwwd_status_t status,
    output lwwd_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ARR  = 5'b00010,
        S_READ = 5'b00100,
        S_CAP  = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    localparam logic [WIN_W-1:0] LAST_WIN = WIN_W'(WINDOW_COUNT - 1);

    state_t           state_reg, state_next;
    logic [WIN_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = (in_kind == KIND_ARRIVE) ? S_ARR : S_READ;
                end
            end
            S_ARR:
            begin
                if (status.out_free)
                begin
                    cmd.arrive = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_CAP;
            end
            S_CAP:
            begin
                cmd.rd_capture = 1'b1;
                if (idx_reg == LAST_WIN)
                begin
                    idx_next   = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_UPD:
            begin
                if (!status.upd_emit || status.out_free)
                begin
                    cmd.update = 1'b1;
                    if (idx_reg == LAST_WIN)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lwwd_datapath.sv
// ----------------------------------------------------------------------------
// lwwd_datapath
// Window FIFOs (one job memory), work totals, counters, service-time
// registers and the output result register.
// ----------------------------------------------------------------------------
module lwwd_datapath
    import lwwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lwwd_cmd_t            cmd,
    output lwwd_status_t         status,
    input  logic [BUS_W-1:0]     in_business,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_type,
    output logic [WINDOW_W-1:0]  out_window,
    output logic [NUMBER_W-1:0]  out_number,
    output logic [TOTAL_W-1:0]   out_wait,
    output logic                 out_accepted,
    output logic                 out_served_now,
    output logic                 out_last
);

    // job memory: no reset; every window's head slot is read, even when empty, but only occupied slots are used
    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;

    logic [PTR_W-1:0]     head_reg  [WINDOW_COUNT];
    logic [PTR_W-1:0]     tail_reg  [WINDOW_COUNT];
    logic [TOTAL_W-1:0]   total_reg [WINDOW_COUNT];
    logic [TIME_BITS-1:0] hval_reg  [WINDOW_COUNT];
    logic [CFG_W-1:0]     svc_reg   [CFG_COUNT];
    logic [NUMBER_W-1:0]  ticket_reg, call_reg;
    logic [BUS_W-1:0]     bus_reg;

    logic                 out_valid_reg;
    logic                 type_reg, acc_reg, now_reg, last_reg;
    logic [WINDOW_W-1:0]  window_reg;
    logic [NUMBER_W-1:0]  number_reg;
    logic [TOTAL_W-1:0]   wait_reg;

    logic [WINDOW_COUNT-1:0] nonempty, emit_mask, dec_mask;
    logic [WIN_W-1:0]        best;
    logic [TIME_BITS-1:0]    svc_time;
    logic [PTR_W-1:0]        tail_inc, head_inc;
    logic                    full;
    logic                    later_emit;
    logic                    cur_emit, cur_dec;
    logic                    out_free, load_out;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;
    logic [TIME_BITS-1:0]    wr_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_SLOTS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [WIN_W-1:0] w,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(ADDR_W'(w) * ADDR_W'(QUEUE_SLOTS)) + ADDR_W'(p);
    endfunction

    always_comb
    begin
        for (int w = 0; w < WINDOW_COUNT; w++)
        begin
            nonempty[w]  = (head_reg[w] != tail_reg[w]);
            emit_mask[w] = nonempty[w] && (hval_reg[w] <= TIME_BITS'(1));
            dec_mask[w]  = nonempty[w] && (hval_reg[w] != '0);
        end
    end

    // least total work, lowest window on a tie
    always_comb
    begin
        best = '0;
        for (int w = 1; w < WINDOW_COUNT; w++)
        begin
            if (total_reg[w] < total_reg[best])
                best = WIN_W'(w);
        end
    end

    always_comb
    begin
        later_emit = 1'b0;
        for (int w = 0; w < WINDOW_COUNT; w++)
        begin
            if ((WIN_W'(w) > cmd.idx) && emit_mask[w])
                later_emit = 1'b1;
        end
    end

    assign svc_time = TIME_BITS'(svc_reg[bus_reg]);
    assign tail_inc = ptr_inc(tail_reg[best]);
    assign head_inc = ptr_inc(head_reg[cmd.idx]);
    assign full     = (tail_inc == head_reg[best]);
    assign cur_emit = emit_mask[cmd.idx];
    assign cur_dec  = dec_mask[cmd.idx];

    assign out_free        = !out_valid_reg || out_ready;
    assign status.out_free = out_free;
    assign status.upd_emit = cur_emit;
    assign load_out        = cmd.arrive || (cmd.update && cur_emit);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_addr(cmd.idx, head_reg[cmd.idx]);
        wr_data = hval_reg[cmd.idx] - 1'b1;
        if (cmd.arrive)
        begin
            wr_en   = !full;
            wr_addr = slot_addr(best, tail_reg[best]);
            wr_data = svc_time;
        end
        else if (cmd.update)
        begin
            wr_en = cur_dec;
        end
    end

    assign rd_addr = slot_addr(cmd.idx, head_reg[cmd.idx]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            bus_reg <= in_business;
        if (cmd.rd_capture)
            hval_reg[cmd.idx] <= rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WINDOW_COUNT; w++)
            begin
                head_reg[w]  <= '0;
                tail_reg[w]  <= '0;
                total_reg[w] <= '0;
            end
            ticket_reg         <= NUMBER_W'(1);
            call_reg           <= NUMBER_W'(1);
            svc_reg[REG_OPEN[1:0]]     <= SVC_OPEN_RST;
            svc_reg[REG_WITHDRAW[1:0]] <= SVC_WITHDRAW_RST;
            svc_reg[REG_DEPOSIT[1:0]]  <= SVC_DEPOSIT_RST;
            svc_reg[REG_OTHER[1:0]]    <= SVC_OTHER_RST;
        end
        else
        begin
            if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_COUNT)))
                svc_reg[cfg_index[1:0]] <= cfg_data;

            if (cmd.arrive)
            begin
                if (!full)
                begin
                    tail_reg[best]  <= tail_inc;
                    total_reg[best] <= total_reg[best] + TOTAL_W'(svc_time);
                end
                ticket_reg <= ticket_reg + 1'b1;
                if (total_reg[best] == '0)
                    call_reg <= call_reg + 1'b1;
            end
            else if (cmd.update)
            begin
                if (cur_dec && (total_reg[cmd.idx] != '0))
                    total_reg[cmd.idx] <= total_reg[cmd.idx] - 1'b1;
                if (cur_emit)
                begin
                    head_reg[cmd.idx] <= head_inc;
                    call_reg          <= call_reg + 1'b1;
                end
            end
        end
    end

    // output result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arrive)
        begin
            type_reg   <= RES_TICKET;
            window_reg <= WINDOW_W'(best);
            number_reg <= ticket_reg;
            wait_reg   <= total_reg[best];
            acc_reg    <= !full;
            now_reg    <= (total_reg[best] == '0);
            last_reg   <= 1'b1;
        end
        else if (cmd.update && cur_emit)
        begin
            type_reg   <= RES_CALL;
            window_reg <= WINDOW_W'(cmd.idx);
            number_reg <= call_reg;
            wait_reg   <= '0;
            acc_reg    <= 1'b0;
            now_reg    <= 1'b0;
            last_reg   <= !later_emit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_type       = type_reg;
    assign out_window     = window_reg;
    assign out_number     = number_reg;
    assign out_wait       = wait_reg;
    assign out_accepted   = acc_reg;
    assign out_served_now = now_reg;
    assign out_last       = last_reg;

endmodule

>>> test/least_work_window_dispatcher_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_dispatch_checker
// Watches the config, arrival/tick and result channels of the dispatcher.
// Keeps its own copy of the window queues and counters, predicts tickets
// and calls, and compares every result item in order.
// ----------------------------------------------------------------------------
module window_dispatch_checker
    import lwwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [0:0]             m_axis_tuser,
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic                res_type;
        logic [WINDOW_W-1:0] window;
        logic [NUMBER_W-1:0] number;
        logic [TOTAL_W-1:0]  wait_ticks;
        logic                accepted;
        logic                served_now;
        logic                last;
    } notice_t;

    logic [CFG_W-1:0]     svc_time [CFG_COUNT];
    logic [TIME_BITS-1:0] job_left [WINDOW_COUNT][QUEUE_SLOTS];
    logic [PTR_W-1:0]     head [WINDOW_COUNT];
    logic [PTR_W-1:0]     tail [WINDOW_COUNT];
    logic [TOTAL_W-1:0]   work [WINDOW_COUNT];
    logic [NUMBER_W-1:0]  ticket_no;
    logic [NUMBER_W-1:0]  call_no;
    notice_t              awaited_notices [$];
    int                   mismatches = 0;

    // Arrival: least total work wins, lowest window on a tie.
    function automatic void issue_ticket(input logic [BUS_W-1:0] biz);
        logic [TIME_BITS-1:0] t;
        int                   best;
        notice_t              tkt;
        t    = TIME_BITS'(svc_time[biz]);
        best = 0;
        for (int w = 1; w < WINDOW_COUNT; w++)
            if (work[w] < work[best])
                best = w;
        tkt            = '0;
        tkt.res_type   = RES_TICKET;
        tkt.window     = WINDOW_W'(best);
        tkt.number     = ticket_no;
        tkt.wait_ticks = work[best];
        tkt.served_now = (work[best] == '0);
        tkt.last       = 1'b1;
        // one slot stays empty, so a queue holds QUEUE_SLOTS-1 jobs
        if (PTR_W'((tail[best] + 1) % QUEUE_SLOTS) != head[best])
        begin
            job_left[best][tail[best]] = t;
            tail[best]   = PTR_W'((tail[best] + 1) % QUEUE_SLOTS);
            work[best]   = work[best] + TOTAL_W'(t);
            tkt.accepted = 1'b1;
        end
        // zero wait bumps the call counter even for a rejected job
        if (tkt.served_now)
            call_no = call_no + 1'b1;
        ticket_no = ticket_no + 1'b1;
        awaited_notices.push_back(tkt);
    endfunction

    // Tick: age every non-empty head; zero-length jobs pop without aging.
    function automatic void age_windows();
        notice_t calls [WINDOW_COUNT];
        int      n;
        n = 0;
        for (int w = 0; w < WINDOW_COUNT; w++)
        begin
            if (head[w] != tail[w])
            begin
                if (job_left[w][head[w]] != '0)
                begin
                    job_left[w][head[w]] = job_left[w][head[w]] - 1'b1;
                    if (work[w] != '0)
                        work[w] = work[w] - 1'b1;
                end
                if (job_left[w][head[w]] == '0)
                begin
                    head[w]           = PTR_W'((head[w] + 1) % QUEUE_SLOTS);
                    calls[n]          = '0;
                    calls[n].res_type = RES_CALL;
                    calls[n].window   = WINDOW_W'(w);
                    calls[n].number   = call_no;
                    call_no           = call_no + 1'b1;
                    n++;
                end
            end
        end
        if (n > 0)
            calls[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_notices.push_back(calls[i]);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        notice_t want;
        if (awaited_notices.size() == 0)
        begin
            $error("result item with no ticket or call outstanding");
            mismatches++;
        end
        else
        begin
            want = awaited_notices.pop_front();
            compare_field("result_type", want.res_type, m_axis_tuser[0]);
            compare_field("window", want.window, m_axis_tdata[WINDOW_W-1:0]);
            compare_field("number", want.number, m_axis_tdata[WINDOW_W +: NUMBER_W]);
            compare_field("wait_ticks", want.wait_ticks,
                          m_axis_tdata[WINDOW_W+NUMBER_W +: TOTAL_W]);
            compare_field("accepted", want.accepted,
                          m_axis_tdata[WINDOW_W+NUMBER_W+TOTAL_W]);
            compare_field("served_now", want.served_now,
                          m_axis_tdata[WINDOW_W+NUMBER_W+TOTAL_W+1]);
            compare_field("last", want.last, m_axis_tlast);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_time[REG_OPEN]     = SVC_OPEN_RST;
            svc_time[REG_WITHDRAW] = SVC_WITHDRAW_RST;
            svc_time[REG_DEPOSIT]  = SVC_DEPOSIT_RST;
            svc_time[REG_OTHER]    = SVC_OTHER_RST;
            for (int w = 0; w < WINDOW_COUNT; w++)
            begin
                head[w] = '0;
                tail[w] = '0;
                work[w] = '0;
            end
            ticket_no = 1;
            call_no   = 1;
            awaited_notices.delete();
        end
        else
        begin
            // a result leaving now belongs to an earlier item
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_valid && cfg_ready && cfg_index < CFG_COUNT)
                svc_time[cfg_index] = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == KIND_ARRIVE)
                    issue_ticket(s_axis_tdata[BUS_W-1:0]);
                else
                    age_windows();
            end
        end
        pending    <= awaited_notices.size();
        fail_count <= mismatches;
    end

endmodule

>>> test/least_work_window_dispatcher_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_work_window_dispatcher_core_test
// Drives arrivals and ticks into the dispatcher under several service-time
// settings and idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module least_work_window_dispatcher_core_test;
    import lwwd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 3 * WINDOW_COUNT + 1 + 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [1:0] business
    logic [0:0]             s_axis_tuser = '0;   // [0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // [1:0] window, [17:2] number, [31:18] wait_ticks, [32] accepted,
    // [33] served_now
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;        // [0] result_type
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    int fail_count;
    int pending;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    least_work_window_dispatcher_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    window_dispatch_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("least_work_window_dispatcher_core_test: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item
    // is taken, with tvalid still high.
    task automatic put_item(input logic kind, input logic [BUS_W-1:0] biz);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = IN_TDATA_W'(biz);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // all four service times, then a write to an unused index
    task automatic load_service_times(input logic [CFG_W-1:0] t_open,
                                      input logic [CFG_W-1:0] t_withdraw,
                                      input logic [CFG_W-1:0] t_deposit,
                                      input logic [CFG_W-1:0] t_other);
        write_reg(REG_OPEN, t_open);
        write_reg(REG_WITHDRAW, t_withdraw);
        write_reg(REG_DEPOSIT, t_deposit);
        write_reg(REG_OTHER, t_other);
        write_reg(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)),
                  CFG_W'($urandom));
        cfg_valid = 1'b0;
    endtask

    // sender quiet until every result is out, then let a silent tick finish
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int arrive_pct;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset service times: empty tick, one arrival per window, then
        // ticks until the deposit window empties
        put_item(KIND_TICK, BUS_W'($urandom_range(3)));
        for (int b = 0; b < 4; b++)
            put_item(KIND_ARRIVE, BUS_W'(b));
        repeat (10)
            put_item(KIND_TICK, BUS_W'($urandom_range(3)));
        drain_results();

        // zero-length jobs pile onto the idle window until it rejects
        load_service_times('0, '0, '0, '0);
        repeat (QUEUE_SLOTS + 2)
            put_item(KIND_ARRIVE, BUS_W'($urandom_range(3)));
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            arrive_pct = 50;
            case (phase)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    load_service_times(8'd255, 8'd1, 8'd255, 8'd1);
                end
                1:
                begin
                    send_gap_pct   = 88;
                    recv_stall_pct = 0;
                    arrive_pct     = 60;
                    load_service_times(8'd1, 8'd1, 8'd1, 8'd1);
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 88;
                    load_service_times(CFG_W'($urandom_range(1, 6)),
                                       CFG_W'($urandom_range(1, 6)),
                                       CFG_W'($urandom_range(1, 6)),
                                       CFG_W'($urandom_range(0, 6)));
                end
                default:
                begin
                    send_gap_pct   = 33;
                    recv_stall_pct = 33;
                    load_service_times(CFG_W'($urandom), CFG_W'($urandom),
                                       CFG_W'($urandom), CFG_W'($urandom));
                end
            endcase
            repeat (RANDOM_ITEMS)
                put_item(($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_TICK,
                         BUS_W'($urandom_range(3)));
            drain_results();
        end

        if (fail_count == 0)
            $display("least_work_window_dispatcher_core_test: done, clean");
        else
            $display("least_work_window_dispatcher_core_test: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/lwwd_pkg.sv
hdl/lwwd_ctrl.sv
hdl/lwwd_datapath.sv
hdl/least_work_window_dispatcher_core.sv
test/least_work_window_dispatcher_core_checker.sv
test/least_work_window_dispatcher_core_test.sv
